// File: design/blpm_pkg.sv
package blpm_pkg;

  // key and trie geometry
  localparam int KEY_W      = 32;
  localparam int LEN_W      = $clog2(KEY_W + 1);
  localparam int KPOS_W     = (KEY_W > 1) ? $clog2(KEY_W) : 1;
  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // one trie node: two child indexes (zero means none) and an end mark
  typedef struct packed {
    logic [IDX_W-1:0] kid1;
    logic [IDX_W-1:0] kid0;
    logic             is_end;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_MARK,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic walk_eval;
    logic walk_step;
    logic capture;
    logic alloc_step;
    logic mark;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_more;
    logic finish;
    logic path_exists;
    logic alloc_last;
    logic out_free;
  } sts_t;

endpackage

// File: design/blpm_ifs.sv
interface blpm_in_if import blpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key_bits;
  logic [LEN_W-1:0] key_length;

  modport source (output valid, output mode, output key_bits, output key_length,
                  input ready);
  modport sink (input valid, input mode, input key_bits, input key_length,
                output ready);
endinterface

interface blpm_out_if import blpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             matched;
  logic [LEN_W-1:0] match_length;
  logic             pool_full;

  modport source (output valid, output matched, output match_length, output pool_full,
                  input ready);
  modport sink (input valid, input matched, input match_length, input pool_full,
                output ready);
endinterface

// File: design/blpm_ctrl.sv
module blpm_ctrl import blpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        priority if (sts.walk_more) state_nxt = ST_WALK;
        else if (sts.finish)        state_nxt = ST_RESULT;
        else if (sts.path_exists)   state_nxt = ST_MARK;
        else                        state_nxt = ST_ALLOC;
      end
      ST_ALLOC: begin
        if (sts.alloc_last) state_nxt = ST_MARK;
      end
      ST_MARK: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WALK: begin
        cmd.walk_eval = 1'b1;
        cmd.walk_step = sts.walk_more;
        cmd.capture   = !sts.walk_more;
      end
      ST_ALLOC: begin
        cmd.alloc_step = 1'b1;
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
      end
      ST_RESULT: begin
        cmd.res_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/blpm_datapath.sv
module blpm_datapath import blpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_mode,
  input  logic [KEY_W-1:0] in_key_bits,
  input  logic [LEN_W-1:0] in_key_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_matched,
  output logic [LEN_W-1:0] out_match_length,
  output logic             out_pool_full
);

  // node memory, root kept in flops
  node_t mem [NODE_COUNT];
  node_t rd_q;

  logic [IDX_W-1:0] root_kid0_r, root_kid1_r;
  logic [CNT_W-1:0] used_r;

  // item registers
  logic             mode_r;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] depth_r;
  logic             at_root_r;
  logic [IDX_W-1:0] cur_addr_r;
  logic             found_r;
  logic [LEN_W-1:0] best_r;
  logic             full_r;
  logic [IDX_W-1:0] par_addr_r;
  node_t            par_data_r;
  logic             par_root_r;

  // result register
  logic             out_valid_r;
  logic             out_matched_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_full_r;

  logic [LEN_W-1:0] len_sat;
  node_t            cur;
  logic             key_bit;
  logic [IDX_W-1:0] child;
  logic [LEN_W-1:0] need;
  logic [CNT_W-1:0] free_cnt;
  logic             no_room;
  logic [IDX_W-1:0] fresh;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  node_t            wr_data;
  node_t            linked;

  // length saturates at the key width
  assign len_sat = (in_key_length > LEN_W'(KEY_W)) ? LEN_W'(KEY_W) : in_key_length;

  // current node contents
  always_comb begin
    if (at_root_r) begin
      cur.kid1   = root_kid1_r;
      cur.kid0   = root_kid0_r;
      cur.is_end = 1'b0;
    end else begin
      cur = rd_q;
    end
  end

  assign key_bit  = key_r[KPOS_W'(KEY_W - 1) - depth_r[KPOS_W-1:0]];
  assign child    = key_bit ? cur.kid1 : cur.kid0;
  assign need     = len_r - depth_r;
  assign free_cnt = CNT_W'(NODE_COUNT) - used_r;
  assign no_room  = CMP_W'(need) > CMP_W'(free_cnt);
  assign fresh    = used_r[IDX_W-1:0];

  // status to controller
  assign sts.walk_more   = (depth_r < len_r) && (child != '0);
  assign sts.finish      = (mode_r == MODE_LOOKUP) || (len_r == '0) || no_room;
  assign sts.path_exists = (need == '0);
  assign sts.alloc_last  = (depth_r == len_r - LEN_W'(1));
  assign sts.out_free    = !out_valid_r || out_ready;

  // parent entry with the new child linked on the walked branch
  always_comb begin
    linked = par_data_r;
    if (key_bit) linked.kid1 = fresh;
    else         linked.kid0 = fresh;
  end

  // memory write port
  always_comb begin
    wr_en   = (cmd.alloc_step || cmd.mark) && !par_root_r;
    wr_addr = par_addr_r;
    wr_data = linked;
    if (cmd.mark) begin
      wr_data        = par_data_r;
      wr_data.is_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) rd_q <= mem[child];
  end

  // root links and pool count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_kid0_r <= '0;
      root_kid1_r <= '0;
      used_r      <= CNT_W'(1);
    end else if (cmd.alloc_step) begin
      used_r <= used_r + CNT_W'(1);
      if (par_root_r) begin
        root_kid0_r <= linked.kid0;
        root_kid1_r <= linked.kid1;
      end
    end
  end

  // item walk state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r     <= in_mode;
      key_r      <= in_key_bits;
      len_r      <= len_sat;
      depth_r    <= '0;
      at_root_r  <= 1'b1;
      cur_addr_r <= '0;
      found_r    <= 1'b0;
      best_r     <= '0;
      full_r     <= 1'b0;
    end
    if (cmd.walk_eval && !at_root_r && rd_q.is_end) begin
      found_r <= 1'b1;
      best_r  <= depth_r;
    end
    if (cmd.walk_step) begin
      depth_r    <= depth_r + LEN_W'(1);
      at_root_r  <= 1'b0;
      cur_addr_r <= child;
    end
    if (cmd.capture) begin
      par_addr_r <= cur_addr_r;
      par_data_r <= cur;
      par_root_r <= at_root_r;
      full_r     <= (mode_r == MODE_INSERT) && (len_r != '0) && no_room;
    end
    if (cmd.alloc_step) begin
      par_addr_r <= fresh;
      par_data_r <= '0;
      par_root_r <= 1'b0;
      depth_r    <= depth_r + LEN_W'(1);
    end
  end

  // result register, freed by the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_matched_r <= (mode_r == MODE_LOOKUP) && found_r;
      out_len_r     <= (mode_r == MODE_LOOKUP) ? best_r : '0;
      out_full_r    <= full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_match_length = out_len_r;
  assign out_pool_full    = out_full_r;

endmodule

// File: design/binary_trie_longest_prefix_match.sv
// Binary trie with longest-prefix match over a node memory.
// in_ch carries one item per transfer: mode 0 inserts the prefix made of the
// top key_length bits of key_bits, mode 1 looks up key_bits as an address.
// out_ch returns exactly one result per item: matched and match_length for a
// lookup, pool_full for an insert refused because free nodes ran out.
// One item is in work at a time. The walk reads the node memory once per key
// bit; an insert builds each new node in place of a walk step and ends with an
// end-mark write. A refused insert ends right after its walk. The controller
// returns to idle in the cycle after the result is loaded and takes the next
// item there.
// A finished result sits in an output register; the next item is accepted
// while it waits, and the block holds its following result until out_ch.ready.
// Reset empties the trie (root without children) and the node pool; no memory
// clearing pass is needed, since nodes are written when allocated.
module binary_trie_longest_prefix_match import blpm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  blpm_in_if.sink    in_ch,
  blpm_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  blpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // node memory and walk datapath
  blpm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_ch.mode),
    .in_key_bits      (in_ch.key_bits),
    .in_key_length    (in_ch.key_length),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_matched      (out_ch.matched),
    .out_match_length (out_ch.match_length),
    .out_pool_full    (out_ch.pool_full)
  );

`ifndef SYNTH
  // a lookup match and a refused insert never come together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.matched && out_ch.pool_full))
    else $error("matched and pool_full both set");

  // a match always has a nonzero length, no match reports zero
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.matched == (out_ch.match_length != '0)))
    else $error("match_length disagrees with matched");

  // only one item in work: input closes right after a transfer
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while one is in work");
`endif

endmodule
